// File: hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants of the decimal text parser.
// Character codes, default widths and the flag group that the parser core
// hands to the top level.
// ----------------------------------------------------------------------------
package dtf_pkg;

  // Default widths of the integer and fraction parts of the result.
  localparam int INT_BITS_DEFAULT  = 23;
  localparam int FRAC_BITS_DEFAULT = 32;

  // Width of the result value; fixed by the output field.
  localparam int VALUE_BITS = 56;

  // Fraction digits after which the digit weight is zero for any
  // fraction width up to 32 bits (10^10 exceeds 2^32).
  localparam int FRAC_DIGITS_MAX = 10;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  // Status flags of the parser core.
  typedef struct packed {
    logic negative;
    logic error_seen;
    logic overflow_seen;
  } dtf_flags_t;

endpackage

// File: hw/rtl/dtf_text_if.sv
// ----------------------------------------------------------------------------
// dtf_text_if: character stream channel.
// One beat carries one text byte or the end-of-text marker.
// ----------------------------------------------------------------------------
interface dtf_text_if ();

  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink (input valid, input character, input end_of_text, output ready);

endinterface

// File: hw/rtl/dtf_result_if.sv
// ----------------------------------------------------------------------------
// dtf_result_if: parsed number channel.
// One beat carries the fixed-point value and its two status flags.
// ----------------------------------------------------------------------------
interface dtf_result_if import dtf_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         syntax_error;
  logic                         overflow;

  modport source (output valid, output value, output syntax_error, output overflow,
                  input ready);
  modport sink (input valid, input value, input syntax_error, input overflow,
                output ready);

endinterface

// File: hw/rtl/dtf_parse.sv
// ----------------------------------------------------------------------------
// dtf_parse: parser state and per-character update.
// Holds phase, sign, integer and fraction accumulators and the error and
// overflow flags; advances them by one character per step.
// ----------------------------------------------------------------------------
module dtf_parse import dtf_pkg::*; #(
  parameter int INT_BITS  = INT_BITS_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 clear,
  input  logic [7:0]           character,
  output logic [INT_BITS-1:0]  integer_part,
  output logic [FRAC_BITS-1:0] fraction_part,
  output dtf_flags_t           flags
);

  localparam int CNT_BITS = $clog2(FRAC_DIGITS_MAX + 1);

  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_INT    = 2'd2;
  localparam logic [1:0] PH_FRAC   = 2'd3;

  localparam logic [INT_BITS+3:0] INT_LIMIT = {4'b0, {INT_BITS{1'b1}}};

  logic [1:0]          phase, phase_next;
  logic [CNT_BITS-1:0] frac_count, frac_count_next;
  logic [INT_BITS-1:0] integer_next;
  logic [FRAC_BITS-1:0] fraction_next;
  dtf_flags_t          flags_next;

  // Weight of the k-th fraction digit: floor(2^FRAC_BITS / 10^k).
  logic [FRAC_BITS-1:0] weight_tab [1:FRAC_DIGITS_MAX];

  for (genvar k = 1; k <= FRAC_DIGITS_MAX; k++) begin : g_weight
    localparam logic [63:0] POW = 64'd10 ** k;
    localparam logic [63:0] W   = (64'd1 << FRAC_BITS) / POW;
    assign weight_tab[k] = W[FRAC_BITS-1:0];
  end

  logic                  is_digit, is_space;
  logic [3:0]            digit;
  logic [INT_BITS+3:0]   int_sum;
  logic [CNT_BITS-1:0]   weight_index;
  logic [FRAC_BITS+3:0]  frac_product;

  always_comb begin
    is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    is_space = ((character >= CHAR_TAB) && (character <= CHAR_CR)) ||
               (character == CHAR_SPACE);
    digit    = is_digit ? 4'(character - CHAR_ZERO) : 4'd0;

    int_sum = {1'b0, integer_part, 3'b000} + {3'b000, integer_part, 1'b0} +
              {{INT_BITS{1'b0}}, digit};

    weight_index = (frac_count == CNT_BITS'(FRAC_DIGITS_MAX)) ?
                   frac_count : frac_count + 1'b1;
    frac_product = {4'b0, weight_tab[weight_index]} * {{FRAC_BITS{1'b0}}, digit};
  end

  always_comb begin
    phase_next      = phase;
    frac_count_next = frac_count;
    integer_next    = integer_part;
    fraction_next   = fraction_part;
    flags_next      = flags;

    if (clear) begin
      phase_next      = PH_SPACE;
      frac_count_next = '0;
      integer_next    = '0;
      fraction_next   = '0;
      flags_next      = '0;
    end else if (step && !flags.error_seen) begin
      if (is_digit && phase != PH_FRAC) begin
        phase_next = PH_INT;
        if (int_sum > INT_LIMIT) begin
          integer_next             = {INT_BITS{1'b1}};
          flags_next.overflow_seen = 1'b1;
        end else begin
          integer_next = int_sum[INT_BITS-1:0];
        end
      end else begin
        unique case (phase)
          PH_SPACE: begin
            if (character == CHAR_PLUS || character == CHAR_MINUS) begin
              flags_next.negative = (character == CHAR_MINUS);
              phase_next          = PH_SIGNED;
            end else if (!is_space) begin
              flags_next.error_seen = 1'b1;
            end
          end
          PH_SIGNED: begin
            flags_next.error_seen = 1'b1;
          end
          PH_INT: begin
            if (character == CHAR_DOT) begin
              phase_next = PH_FRAC;
            end else begin
              flags_next.error_seen = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              frac_count_next = weight_index;
              fraction_next   = fraction_part + frac_product[FRAC_BITS-1:0];
            end else begin
              flags_next.error_seen = 1'b1;
            end
          end
          default: begin
            flags_next.error_seen = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      frac_count    <= '0;
      integer_part  <= '0;
      fraction_part <= '0;
      flags         <= '0;
    end else begin
      phase         <= phase_next;
      frac_count    <= frac_count_next;
      integer_part  <= integer_next;
      fraction_part <= fraction_next;
      flags         <= flags_next;
    end
  end

endmodule

// File: hw/rtl/decimal_text_to_fixed_point_top.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top: decimal text to signed fixed point.
// Parses a decimal number arriving one character per beat and returns it as
// a signed value with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage: the text channel delivers one byte per beat. Leading whitespace is
// skipped, one optional sign may follow, then integer digits, an optional dot
// and fraction digits. A beat with end_of_text set ends the number: one beat
// on the result channel carries the value, the syntax error flag and the
// overflow flag, and the parser returns to its empty state. Other beats
// produce no result.
// Throughput is one text beat per cycle; each character is folded into the
// accumulators by the parser core in the cycle it is accepted. The result of
// a terminator beat appears on the result channel in the cycle after acceptance.
// The result register acts as the output stage: while it holds a beat that is
// not taken, the text channel stalls; it accepts again in the cycle the
// receiver takes the result, so there is no bubble under back-pressure.
// Reset (synchronous, active high) empties the result register and returns
// the parser to the whitespace phase with cleared accumulators and flags.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_top import dtf_pkg::*; #(
  parameter int INT_BITS  = INT_BITS_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dtf_text_if.sink     text,
  dtf_result_if.source result
);

  logic                 accept;
  logic                 step;
  logic                 clear;
  logic [INT_BITS-1:0]  integer_part;
  logic [FRAC_BITS-1:0] fraction_part;
  dtf_flags_t           flags;

  logic                         result_valid;
  logic signed [VALUE_BITS-1:0] result_value;
  logic                         result_error;
  logic                         result_overflow;

  logic [63:0] magnitude;
  logic [63:0] signed_value;

  // A new beat is taken whenever the result register is empty or is being
  // drained in this cycle.
  assign text.ready = !result_valid || result.ready;
  assign accept     = text.valid && text.ready;
  assign step       = accept && !text.end_of_text;
  assign clear      = accept && text.end_of_text;

  dtf_parse #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .clear         (clear),
    .character     (text.character),
    .integer_part  (integer_part),
    .fraction_part (fraction_part),
    .flags         (flags)
  );

  // The magnitude joins the integer and fraction parts; the sign is applied
  // by a two's complement negate, and an error forces the value to zero.
  always_comb begin
    magnitude    = 64'({integer_part, fraction_part});
    signed_value = flags.negative ? (64'd0 - magnitude) : magnitude;
    if (flags.error_seen) begin
      signed_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (clear) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  // Payload is loaded with the state as it stands before the terminator
  // clears the parser.
  always_ff @(posedge clk) begin
    if (clear) begin
      result_value    <= signed_value[VALUE_BITS-1:0];
      result_error    <= flags.error_seen;
      result_overflow <= flags.overflow_seen;
    end
  end

  assign result.valid        = result_valid;
  assign result.value        = result_value;
  assign result.syntax_error = result_error;
  assign result.overflow     = result_overflow;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the decimal text to fixed point parser.
// Feeds directed and random character streams through the text channel and
// checks every number on the result channel against a scoreboard that
// folds each accepted character into its own copy of the parser state.
// ----------------------------------------------------------------------------
import dtf_pkg::*;

localparam int INT_W  = INT_BITS_DEFAULT;
localparam int FRAC_W = FRAC_BITS_DEFAULT;

typedef enum logic [2:0] {
  SCAN_SPACE,
  SCAN_SIGNED,
  SCAN_INTEGER,
  SCAN_FRACTION
} scan_phase_e;

typedef struct packed {
  logic signed [VALUE_BITS-1:0] value;
  logic                         syntax_error;
  logic                         overflow;
} parsed_number_t;

// Tracks the parser state from accepted text beats and holds the numbers
// that the result channel still owes.
class number_scoreboard;
  scan_phase_e        phase;
  bit                 negative;
  bit [INT_W-1:0]     int_part;
  bit [FRAC_W-1:0]    frac_part;
  bit [32:0]          weight;
  bit                 error_seen;
  bit                 overflow_seen;
  parsed_number_t     expected_numbers[$];
  int                 fails;

  function new();
    fails = 0;
    clear_parser();
  endfunction

  function void clear_parser();
    phase         = SCAN_SPACE;
    negative      = 1'b0;
    int_part      = '0;
    frac_part     = '0;
    weight        = 33'(64'd1 << FRAC_W);
    error_seen    = 1'b0;
    overflow_seen = 1'b0;
  endfunction

  function void add_integer_digit(logic [3:0] d);
    logic [INT_W+4:0] next;
    next = int_part * 10 + d;
    if (next > (2 ** INT_W) - 1) begin
      next          = (2 ** INT_W) - 1;
      overflow_seen = 1'b1;
    end
    int_part = next[INT_W-1:0];
    phase    = SCAN_INTEGER;
  endfunction

  function void add_fraction_digit(logic [3:0] d);
    weight    = weight / 10;
    frac_part = frac_part + d * weight;
  endfunction

  // Returns 0 when the beat was ignored because an error was already seen, 1 otherwise.
  function bit note_text(logic [7:0] ch, logic eot);
    logic [VALUE_BITS-1:0] magnitude;
    parsed_number_t        num;
    bit                    digit;
    bit                    blank;
    logic [3:0]            d;
    if (eot) begin
      magnitude        = {int_part, frac_part};
      num.value        = error_seen ? '0 : (negative ? -magnitude : magnitude);
      num.syntax_error = error_seen;
      num.overflow     = overflow_seen;
      expected_numbers.push_back(num);
      clear_parser();
      return 1'b1;
    end
    if (error_seen) return 1'b0;
    digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    blank = ((ch >= CHAR_TAB) && (ch <= CHAR_CR)) || (ch == CHAR_SPACE);
    d     = 4'(ch - CHAR_ZERO);
    case (phase)
      SCAN_SPACE: begin
        if (blank) begin
        end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
          negative = (ch == CHAR_MINUS);
          phase    = SCAN_SIGNED;
        end else if (digit) begin
          add_integer_digit(d);
        end else begin
          error_seen = 1'b1;
        end
      end
      SCAN_SIGNED: begin
        if (digit) add_integer_digit(d);
        else error_seen = 1'b1;
      end
      SCAN_INTEGER: begin
        if (digit) add_integer_digit(d);
        else if (ch == CHAR_DOT) phase = SCAN_FRACTION;
        else error_seen = 1'b1;
      end
      default: begin
        if (digit) add_fraction_digit(d);
        else error_seen = 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  function int pending();
    return expected_numbers.size();
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  task check_number(logic signed [VALUE_BITS-1:0] value, logic syntax_error,
                    logic overflow);
    parsed_number_t want;
    if (expected_numbers.size() == 0) begin
      report($sformatf("unexpected result beat, value %0d", value));
      return;
    end
    want = expected_numbers.pop_front();
    if (value !== want.value)
      report($sformatf("value %0d, expected %0d", value, want.value));
    if (syntax_error !== want.syntax_error)
      report($sformatf("syntax_error %b, expected %b", syntax_error, want.syntax_error));
    if (overflow !== want.overflow)
      report($sformatf("overflow %b, expected %b", overflow, want.overflow));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Items to push through before the run winds down, and the watchdog limit
  // in cycles with no beat on either channel. The longest legal quiet spell
  // is the long receiver hold, well below the limit.
  localparam int TARGET_ITEMS   = 1400;
  localparam int SEGMENT_ITEMS  = 150;
  localparam int LONG_HOLD      = 60;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  logic clk;
  logic rst;

  dtf_text_if   text_ch ();
  dtf_result_if result_ch ();

  decimal_text_to_fixed_point_top #(
    .INT_BITS  (INT_W),
    .FRAC_BITS (FRAC_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  number_scoreboard board;
  text_beat_t       pending_text[$];
  int               consumed;
  int               quiet_cycles;
  // When calm is set, neither side inserts idle cycles.
  bit               calm;
  // Set by the stimulus to make the receiver hold ready low for a long while.
  bit               hold_long;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The watchdog counts cycles in which neither channel moves a beat. A hang
  // anywhere in the pipeline ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic text_beat_t beat_of(logic [7:0] ch, logic eot);
    text_beat_t b;
    b.ch  = ch;
    b.eot = eot;
    return b;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_text.push_back(beat_of(s[i], 1'b0));
  endfunction

  // The character that rides along with a terminator must be ignored, so it
  // is always random.
  function automatic void push_eot();
    pending_text.push_back(beat_of(8'($urandom_range(0, 255)), 1'b1));
  endfunction

  // Whitespace is one of the control codes from tab to carriage return, or
  // a plain space.
  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // Characters that are legal somewhere in a number, used to break the
  // structure of an otherwise well-formed one.
  function automatic logic [7:0] misplaced_char();
    case ($urandom_range(0, 3))
      0: return CHAR_DOT;
      1: return CHAR_PLUS;
      2: return CHAR_MINUS;
      default: return blank_char();
    endcase
  endfunction

  // Builds one number. Most are well formed with random content: leading
  // blanks, an optional sign, integer digits (now and then enough to
  // saturate), an optional dot and fraction digits (now and then more than
  // the weight can carry). About one in five gets stray characters inserted.
  function automatic void queue_number();
    text_beat_t seq[$];
    int         int_n;
    int         frac_n;
    int         pos;
    logic [7:0] junk;
    repeat ($urandom_range(0, 2)) seq.push_back(beat_of(blank_char(), 1'b0));
    case ($urandom_range(0, 2))
      1: seq.push_back(beat_of(CHAR_PLUS, 1'b0));
      2: seq.push_back(beat_of(CHAR_MINUS, 1'b0));
      default: ;
    endcase
    int_n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
    repeat (int_n) seq.push_back(beat_of(digit_char(), 1'b0));
    if ($urandom_range(0, 3) != 0) begin
      seq.push_back(beat_of(CHAR_DOT, 1'b0));
      frac_n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 13) : $urandom_range(0, 6);
      repeat (frac_n) seq.push_back(beat_of(digit_char(), 1'b0));
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pos  = $urandom_range(0, seq.size());
        junk = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : misplaced_char();
        seq.insert(pos, beat_of(junk, 1'b0));
      end
    end
    foreach (seq[i]) pending_text.push_back(seq[i]);
    push_eot();
  endfunction

  // Offers one text beat and returns at the falling edge after it was
  // accepted. Idle cycles drop valid first so that gaps land anywhere in
  // the parse, including between a terminator and the next number.
  task automatic send_beat(text_beat_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.character   <= b.ch;
    text_ch.end_of_text <= b.eot;
    do @(posedge clk); while (!text_ch.ready);
    void'(board.note_text(b.ch, b.eot));
    consumed++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (pending_text.size() != 0) send_beat(pending_text.pop_front());
  endtask

  // The sender goes quiet until every expected number has come back.
  task automatic drain();
    text_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver. Before each result it draws a stall, counted in cycles in
  // which a result is actually waiting, so a nonzero stall always bites. On
  // request it holds ready low for a long stretch; the single result
  // register then fills and the text channel must stall behind it.
  initial begin
    int stall;
    int seen;
    result_ch.ready <= 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_long) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        @(negedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        seen = 0;
        while (seen < stall) begin
          @(posedge clk);
          if (result_ch.valid) seen++;
        end
        @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      board.check_number(result_ch.value, result_ch.syntax_error, result_ch.overflow);
      @(negedge clk);
    end
  end

  // Main sequence: reset, a short directed pass over the special cases, then
  // random segments that mix idling and back-to-back traffic.
  initial begin
    int seg;
    int seg_start;
    board                = new();
    consumed             = 0;
    quiet_cycles         = 0;
    calm                 = 1'b0;
    hold_long            = 1'b0;
    rst                 <= 1'b1;
    text_ch.valid       <= 1'b0;
    text_ch.character   <= '0;
    text_ch.end_of_text <= 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty text gives zero.
    push_eot();
    // A sign on its own is valid and also gives zero.
    push_text("-");
    push_eot();
    // Leading blanks, then digits that end in a dot.
    pending_text.push_back(beat_of(CHAR_TAB, 1'b0));
    push_text(" 7.");
    push_eot();
    // A dot right after the sign is an error.
    push_text("+.");
    push_eot();
    // A second dot is an error.
    push_text("1..");
    push_eot();
    // A second sign is an error.
    push_text("-+");
    push_eot();
    // Seven nines exceed the integer range and saturate.
    pending_text.push_back(beat_of(CHAR_CR, 1'b0));
    push_text("9999999");
    push_eot();
    // A byte with every bit set is simply an invalid character.
    pending_text.push_back(beat_of(8'hff, 1'b0));
    push_eot();
    send_queued();
    drain();

    // Segment one runs back to back while the receiver takes its long hold.
    // Every third segment is free of idle cycles; the rest idle at random.
    // Each segment ends with the sender waiting until all results are in.
    seg = 0;
    while (consumed < TARGET_ITEMS) begin
      calm = (seg % 3 == 2) || (seg == 1);
      if (seg == 1) hold_long = 1'b1;
      seg_start = consumed;
      while (consumed - seg_start < SEGMENT_ITEMS) begin
        queue_number();
        send_queued();
      end
      drain();
      seg++;
    end

    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_text_if.sv
hw/rtl/dtf_result_if.sv
hw/rtl/dtf_parse.sv
hw/rtl/decimal_text_to_fixed_point_top.sv
bench/tb_top.sv
